[design/ddq_pkg.sv]
package ddq_pkg;

    localparam int DATA_W = 32;
    localparam int OCC_W  = 7;

    typedef enum logic [1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic push_back;
        logic push_front;
        logic pop_front;
        logic pop_back;
    } t_cell_ctrl;

endpackage

[design/ddq_cell.sv]
module ddq_cell
    import ddq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctrl        i_ctrl,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_prev_data,
    input  logic              i_prev_valid,
    input  logic [DATA_W-1:0] i_next_data,
    input  logic              i_next_valid,
    output logic [DATA_W-1:0] o_data,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_tail_data
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;
    logic              r_valid;
    logic              n_valid;
    logic              w_is_tail;
    logic              w_is_slot;

    assign w_is_tail = r_valid && !i_next_valid;
    assign w_is_slot = !r_valid && i_prev_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.push_front) begin
            n_data  = i_prev_data;
            n_valid = i_prev_valid;
        end else if (i_ctrl.pop_front) begin
            n_data  = i_next_data;
            n_valid = i_next_valid;
        end else if (i_ctrl.push_back && w_is_slot) begin
            n_data  = i_value;
            n_valid = 1'b1;
        end else if (i_ctrl.pop_back && w_is_tail) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    assign o_tail_data = w_is_tail ? r_data : '0;

endmodule

[design/double_ended_queue_top.sv]
// Bounded double-ended queue of signed 32-bit words, built as a row of cells.
// Requests arrive on the slave stream: tuser carries the operation (push back,
// push front, pop front, pop back) and tdata the word to push. Each request
// yields exactly one result on the master stream: tuser carries the status
// (ok, empty on pop, full on push), tdata the popped word and the occupancy.
// The front of the queue always sits in the first cell. A push at the front or
// a pop from the front shifts every cell by one place towards its neighbour in
// the same cycle; a push at the back loads the first free cell and a pop from
// the back clears the last held cell, so each request is done as it is accepted.
// The result appears in the cycle after acceptance; one request can be taken every
// cycle while the receiver keeps up. The result is held in an output register;
// while it stalls, a new request is taken only once that register is free.
// Reset empties the queue and discards any waiting result; the stored words
// are left as they were and are never read before being written again.
module double_ended_queue_top
    import ddq_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,   // operation
    input  logic [31:0] i_s_tdata,   // value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [1:0]  o_m_tuser,   // status
    output logic [39:0] o_m_tdata    // popped_value [31:0], occupancy [38:32], zero
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_out_valid;
    logic              n_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [DATA_W-1:0] r_popped;
    logic [DATA_W-1:0] n_popped;
    logic [OCC_W-1:0]  r_occ;
    logic [OCC_W-1:0]  n_occ;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    t_op               w_op;
    t_cell_ctrl        w_ctrl;
    logic [DATA_W-1:0] w_tail_or;

    logic [DATA_W-1:0] w_data   [DEPTH];
    logic              w_valid  [DEPTH];
    logic [DATA_W-1:0] w_tail   [DEPTH];

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CW'(DEPTH));
    assign w_empty    = (r_count == '0);
    assign w_op       = t_op'(i_s_tuser);

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_W-1:0] w_prev_data;
            logic              w_prev_valid;
            logic [DATA_W-1:0] w_next_data;
            logic              w_next_valid;

            if (g == 0) begin : g_first
                assign w_prev_data  = i_s_tdata;
                assign w_prev_valid = 1'b1;
            end else begin : g_mid
                assign w_prev_data  = w_data[g-1];
                assign w_prev_valid = w_valid[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign w_next_data  = '0;
                assign w_next_valid = 1'b0;
            end else begin : g_inner
                assign w_next_data  = w_data[g+1];
                assign w_next_valid = w_valid[g+1];
            end

            ddq_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctrl       (w_ctrl),
                .i_value      (i_s_tdata),
                .i_prev_data  (w_prev_data),
                .i_prev_valid (w_prev_valid),
                .i_next_data  (w_next_data),
                .i_next_valid (w_next_valid),
                .o_data       (w_data[g]),
                .o_valid      (w_valid[g]),
                .o_tail_data  (w_tail[g])
            );
        end
    endgenerate

    always_comb begin
        w_tail_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_tail_or = w_tail_or | w_tail[i];
        end
    end

    always_comb begin
        w_ctrl      = '0;
        n_count     = r_count;
        n_status    = r_status;
        n_popped    = r_popped;
        n_occ       = r_occ;
        n_out_valid = r_out_valid && !i_m_tready;
        if (w_accept) begin
            n_out_valid = 1'b1;
            n_status    = ST_OK;
            n_popped    = '0;
            unique case (w_op)
                OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.push_back = 1'b1;
                        n_count          = r_count + 1'b1;
                    end
                end
                OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_FULL;
                    end else begin
                        w_ctrl.push_front = 1'b1;
                        n_count           = r_count + 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctrl.pop_front = 1'b1;
                        n_popped         = w_data[0];
                        n_count          = r_count - 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_EMPTY;
                    end else begin
                        w_ctrl.pop_back = 1'b1;
                        n_popped        = w_tail_or;
                        n_count         = r_count - 1'b1;
                    end
                end
            endcase
            n_occ = OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_popped <= n_popped;
        r_occ    <= n_occ;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {1'b0, r_occ, r_popped};

endmodule
